### sv/kpd_pkg.sv
package kpd_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned ROW_W = 3;
  localparam int unsigned COL_W = 3;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned DEB_W = 16;

  localparam logic [DEB_W-1:0] DEB_RESET = 16'd50;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_FLUSH
  } kpd_state_e;

endpackage

### sv/kpd_in_if.sv
interface kpd_in_if;
  import kpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_bits;

  modport source (output valid, output key_bits, input ready);
  modport sink (input valid, input key_bits, output ready);
endinterface

### sv/kpd_out_if.sv
interface kpd_out_if;
  import kpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] press_row;
  logic [COL_W-1:0] press_column;
  logic             last_press;

  modport source (output valid, output press_row, output press_column, output last_press,
                  input ready);
  modport sink (input valid, input press_row, input press_column, input last_press,
                output ready);
endinterface

### sv/kpd_cfg_if.sv
interface kpd_cfg_if;
  import kpd_pkg::*;

  logic             valid;
  logic             ready;
  logic [DEB_W-1:0] debounce_scans;

  modport source (output valid, output debounce_scans, input ready);
  modport sink (input valid, input debounce_scans, output ready);
endinterface

### sv/keypad_matrix_press_debounce.sv
// Key matrix press detector with per-key debounce.
//
// in_i   : one item is a full ROWS x COLS snapshot (bit row*COLS+column).
// out_o  : one item per accepted press: row, column and a last_press flag
//          on the final press of that snapshot. A snapshot with no
//          accepted press produces no output item.
// cfg_i  : writes the debounce distance in scans; always ready, and meant
//          to be written only while the block is idle.
//
// Timing: the sequencer walks the keys one per cycle unless a stalled
// receiver holds it, with a pass through ST_CHECK on each rising key for
// the registered stamp read; the final press is pushed from ST_FLUSH after
// the walk, and the next item is taken only once the block is back in
// idle. in_i.ready is high only while idle.
// A found press waits in a pending register until the next press or the
// end of the walk shows whether it is the last one; a stalled receiver
// holds the output register and freezes the walk at the next press.
// Reset clears the scan counter, previous snapshot, the stamp valid bits
// (an unwritten stamp reads as zero, "never pressed") and sets the
// debounce distance to 50. No clearing pass is needed.
module keypad_matrix_press_debounce #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kpd_in_if.sink    in_i,
  kpd_out_if.source out_o,
  kpd_cfg_if.sink   cfg_i
);
  import kpd_pkg::*;

  localparam int unsigned KEYS = ROWS * COLS;
  localparam int unsigned IdxW = (KEYS > 1) ? $clog2(KEYS) : 1;

  // Control and walk state
  kpd_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [KEY_W-1:0] prev_q;
  logic [KEY_W-1:0] rising_q;
  logic [IdxW-1:0]  idx_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [DEB_W-1:0] deb_q;
  logic [KEYS-1:0]  vld_q;
  logic             pend_valid_q;
  logic             out_valid_q;

  // Payload registers
  logic [ROW_W-1:0] pend_row_q;
  logic [COL_W-1:0] pend_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q;
  logic             out_last_q;

  // Stamp memory
  logic [CNT_W-1:0] stamp_mem [KEYS];
  logic [CNT_W-1:0] mem_rd_q;

  // Sequencer controls
  logic             accept;
  logic             rd_en;
  logic             wr_en;
  logic             advance;
  logic             push;
  logic             push_last;
  logic             take_pend;
  logic             clear_pend;

  logic             out_free;
  logic [CNT_W-1:0] stamp;
  logic [CNT_W-1:0] delta;
  logic             hit;
  logic             last_key;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && (state_q == ST_IDLE);

  assign out_o.valid        = out_valid_q;
  assign out_o.press_row    = out_row_q;
  assign out_o.press_column = out_col_q;
  assign out_o.last_press   = out_last_q;

  assign out_free = !out_valid_q || out_o.ready;
  // An unwritten entry reads as zero: never stamped
  assign stamp    = vld_q[idx_q] ? mem_rd_q : '0;
  assign delta    = count_q - stamp;
  assign hit      = (stamp == '0) || (delta >= CNT_W'(deb_q));
  assign last_key = (idx_q == IdxW'(KEYS - 1));

  always_comb begin
    state_d    = state_q;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    advance    = 1'b0;
    push       = 1'b0;
    push_last  = 1'b0;
    take_pend  = 1'b0;
    clear_pend = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Fetch the stamp of a rising key, skip everything else
        if (rising_q[0]) begin
          rd_en   = 1'b1;
          state_d = ST_CHECK;
        end else begin
          advance = 1'b1;
          state_d = last_key ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_CHECK: begin
        // Hold while a new press finds an older one that cannot move into the output register
        if (!(hit && pend_valid_q && !out_free)) begin
          if (hit) begin
            wr_en     = 1'b1;
            take_pend = 1'b1;
            push      = pend_valid_q;
          end
          advance = 1'b1;
          state_d = last_key ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          clear_pend = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      prev_q       <= '0;
      rising_q     <= '0;
      idx_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      deb_q        <= DEB_RESET;
      vld_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        deb_q <= cfg_i.debounce_scans;
      end
      if (accept) begin
        count_q  <= count_q + 1'b1;
        prev_q   <= in_i.key_bits;
        rising_q <= in_i.key_bits & ~prev_q;
        idx_q    <= '0;
        row_q    <= '0;
        col_q    <= '0;
      end else if (advance) begin
        rising_q <= rising_q >> 1;
        idx_q    <= idx_q + 1'b1;
        if (col_q == COL_W'(COLS - 1)) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (wr_en) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (take_pend) begin
        pend_valid_q <= 1'b1;
      end else if (clear_pend) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_pend) begin
      pend_row_q <= row_q;
      pend_col_q <= col_q;
    end
    if (push) begin
      out_row_q  <= pend_row_q;
      out_col_q  <= pend_col_q;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stamp_mem[idx_q] <= count_q;
    end
    if (rd_en) begin
      mem_rd_q <= stamp_mem[idx_q];
    end
  end

endmodule
